### rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 shared definitions
// Types, initial vector and round tables used by the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // One queued beat between the front and the back.
    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } md5_cmd_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

### rtl/md5_cmd_fifo.sv
// ----------------------------------------------------------------------------
// MD5 command queue
// Small queue that decouples input acceptance from block processing.
// ----------------------------------------------------------------------------
module md5_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  md5_pkg::md5_cmd_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output md5_pkg::md5_cmd_t rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    md5_pkg::md5_cmd_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != (AW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow");
    a_empty_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> !do_rd) else $error("read from empty queue");
endmodule

### rtl/md5_core.sv
// ----------------------------------------------------------------------------
// MD5 block engine
// Packs bytes, pads on finish, runs 64 rounds one per cycle, emits the digest.
// ----------------------------------------------------------------------------
module md5_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  md5_pkg::md5_cmd_t cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_digest_word,
    output logic [1:0]        m_word_index,
    output logic              m_last_word
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] buf_reg [16];
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  rnd_reg;
    logic [60:0] count_reg;
    logic        fin_reg;   // finishing: a final block follows or digest emits
    logic        final_reg; // the block in flight carries the length
    logic [1:0]  oidx_reg;

    logic [31:0] f, sum, rot, kk;
    logic [3:0]  g;
    logic [4:0]  s;
    logic [31:0] wsel;
    logic        accept, out_fire;
    logic        len_slot;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign m_valid   = (state_reg == ST_OUT);
    assign out_fire  = m_valid && m_ready;
    assign m_digest_word = md5_pkg::bswap(h_reg[oidx_reg]);
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == 2'd3);
    // In the last block the sweep stops at byte 56, where the length goes.
    assign len_slot  = (state_reg == ST_PAD) && final_reg && (fill_reg == 6'd56);

    always_comb begin
        case (rnd_reg[5:4])
            2'd0: begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = rnd_reg[3:0];
            end
            2'd1: begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(5 * rnd_reg[3:0] + 1);
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(3 * rnd_reg[3:0] + 5);
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(7 * rnd_reg[3:0]);
            end
        endcase
        kk   = md5_pkg::round_const(rnd_reg);
        s    = md5_pkg::rot_amount(rnd_reg);
        wsel = buf_reg[g];
        sum  = a_reg + f + kk + wsel;
        rot  = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) begin
                // A beat that lands in the last byte closes the block at once.
                if (fill_reg == 6'd63) begin
                    state_next = ST_ROUND;
                end else if (cmd.finish == md5_pkg::OP_FINISH) begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:   if (final_reg ? (fill_reg == 6'd56) : (fill_reg == 6'd63)) begin
                state_next = ST_ROUND;
            end
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:   state_next = fin_reg ? (final_reg ? ST_OUT : ST_PAD) : ST_IDLE;
            ST_OUT:   if (out_fire && oidx_reg == 2'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Byte write into the block buffer.
    logic       wr_en;
    logic [7:0] wr_byte;
    always_comb begin
        wr_en   = 1'b0;
        wr_byte = 8'h00;
        if (accept) begin
            wr_en   = 1'b1;
            wr_byte = (cmd.finish == md5_pkg::OP_FINISH) ? 8'h80 : cmd.data;
        end else if (state_reg == ST_PAD && !len_slot) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_reg[fill_reg[5:2]][8*fill_reg[1:0] +: 8] <= wr_byte;
        end
        if (len_slot) begin
            buf_reg[14] <= {count_reg[28:0], 3'b000};
            buf_reg[15] <= count_reg[60:29];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            h_reg[0]  <= md5_pkg::IV_A;
            h_reg[1]  <= md5_pkg::IV_B;
            h_reg[2]  <= md5_pkg::IV_C;
            h_reg[3]  <= md5_pkg::IV_D;
            fill_reg  <= '0;
            rnd_reg   <= '0;
            count_reg <= '0;
            fin_reg   <= 1'b0;
            final_reg <= 1'b0;
            oidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                fill_reg <= fill_reg + 1'b1;
                if (cmd.finish == md5_pkg::OP_FINISH) begin
                    fin_reg   <= 1'b1;
                    // The marker byte leaves room for the length only below 56.
                    final_reg <= (fill_reg < 6'd56);
                end else begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (state_reg == ST_PAD) begin
                fill_reg <= len_slot ? 6'd0 : fill_reg + 1'b1;
            end
            if (state_next == ST_ROUND && state_reg != ST_ROUND) begin
                a_reg   <= h_reg[0];
                b_reg   <= h_reg[1];
                c_reg   <= h_reg[2];
                d_reg   <= h_reg[3];
                rnd_reg <= '0;
            end
            if (state_reg == ST_ROUND) begin
                a_reg   <= d_reg;
                d_reg   <= c_reg;
                c_reg   <= b_reg;
                b_reg   <= b_reg + rot;
                rnd_reg <= rnd_reg + 1'b1;
            end
            if (state_reg == ST_ADD) begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                if (fin_reg && !final_reg) final_reg <= 1'b1;
            end
            if (out_fire) begin
                oidx_reg <= oidx_reg + 1'b1;
                if (oidx_reg == 2'd3) begin
                    h_reg[0]  <= md5_pkg::IV_A;
                    h_reg[1]  <= md5_pkg::IV_B;
                    h_reg[2]  <= md5_pkg::IV_C;
                    h_reg[3]  <= md5_pkg::IV_D;
                    fill_reg  <= '0;
                    count_reg <= '0;
                    fin_reg   <= 1'b0;
                    final_reg <= 1'b0;
                end
            end
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_out_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> fin_reg && final_reg) else $error("digest without finish");
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("rounds did not end in add");
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |-> fill_reg == '0) else $error("block not full");
endmodule

### rtl/md5_message_digest_top.sv
// ----------------------------------------------------------------------------
// MD5 message digest top
// Byte-stream MD5 engine with a command queue in front of the block engine.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat per byte (s_operation = 0) or a finish beat
// (s_operation = 1, s_data_byte ignored). Beats enter a short queue, so a few
// bytes are taken while the engine compresses a block.
// Result channel m_*: a finish produces four beats, chaining words a, b, c, d
// byte-swapped, with m_word_index 0..3 and m_last_word on the fourth.
// An add beat writes one byte into the block buffer; the 64th byte of a block
// starts the one-round-per-cycle compression loop and final add.
// A finish starts a padding sweep of one byte position per cycle up to the
// block end (none when the marker fills the last byte), or in the last block
// up to byte 56, where the length is written, and a compression per padded
// block (one or two), then four result beats.
// A stalled receiver holds the engine in the output state; the queue keeps
// taking input until it is full. Reset (aresetn low) empties the queue and
// restores the initial vector, fill position and byte count.
// ----------------------------------------------------------------------------
module md5_message_digest_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_last_word
);
    md5_pkg::md5_cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;

    assign in_cmd.finish = s_operation;
    assign in_cmd.data   = s_data_byte;

    md5_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_data(in_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    md5_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_digest_word(m_digest_word), .m_word_index(m_word_index),
        .m_last_word(m_last_word)
    );
endmodule
